// File: sv/max_gap_point_set_unit_defines.svh
// Assertion macros for the maximum-gap point set unit.
`ifndef MAX_GAP_POINT_SET_UNIT_DEFINES_SVH
`define MAX_GAP_POINT_SET_UNIT_DEFINES_SVH
`ifndef SYNTH
`define MGPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MGPS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MGPS_ASSERT(label, clk, rst_n, prop, msg)
`define MGPS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: sv/mgps_pkg.sv
// Package for the maximum-gap point set unit: types, codes and defaults.
package mgps_pkg;
    localparam int unsigned POS_BITS_DEF   = 10;
    localparam int unsigned COUNT_BITS_DEF = 16;
    localparam int unsigned LEN_BITS       = 10;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_WRITE, S_SCAN, S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic load;
        logic rd;
        logic wr;
        logic scan_start;
        logic scan_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic scan_last;
    } t_stat;
endpackage

// File: sv/mgps_datapath.sv
// Datapath: count memory, occupancy memory, scan engine and result register.
module mgps_datapath import mgps_pkg::*; #(
    parameter int unsigned POS_BITS   = POS_BITS_DEF,
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [LEN_BITS-1:0] i_len,
    input  logic [1:0]          i_command,
    input  logic [9:0]          i_position,
    output logic [9:0]          o_largest_gap,
    output logic [1:0]          o_status
);
    localparam int unsigned DEPTH = 1 << POS_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] r_cnt_mem [DEPTH];
    logic                  r_occ_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rd_cnt;
    logic                  r_occ_rd;

    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic [1:0]            r_cmd;
    logic [POS_BITS:0]     r_clr;
    logic [POS_BITS:0]     r_p;
    logic [POS_BITS:0]     r_prev;
    logic [POS_BITS:0]     r_best;
    logic                  r_chk;
    logic [POS_BITS:0]     r_chk_p;
    logic [1:0]            r_status;
    logic [9:0]            r_gap;
    logic [1:0]            r_ostat;

    logic                  in_range;
    logic [COUNT_BITS-1:0] new_cnt;
    logic [1:0]            op_status;
    logic                  do_wr;
    logic [POS_BITS:0]     gap_here, gap_end, best_fin;
    logic [POS_BITS-1:0]   wr_addr;
    logic                  wr_occ;
    logic [POS_BITS:0]     len_ext;

    // Position taken from the 10-bit field and masked to the address width.
    always_comb begin
        if (POS_BITS >= 10) n_pos = POS_BITS'(i_position);
        else                n_pos = i_position[POS_BITS-1:0];
    end
    assign len_ext  = (POS_BITS >= LEN_BITS) ? (POS_BITS+1)'(i_len)
                                             : (POS_BITS+1)'(i_len & ((1 << POS_BITS) - 1));

    // Update decision for add and remove.
    always_comb begin
        in_range  = (r_pos != '0) && ((POS_BITS+1)'(r_pos) < len_ext);
        new_cnt   = r_rd_cnt;
        op_status = ST_OK;
        do_wr     = 1'b0;
        if (r_cmd == CMD_ADD || r_cmd == CMD_REMOVE) begin
            if (!in_range) begin
                op_status = ST_RANGE;
            end else if (r_cmd == CMD_ADD) begin
                if (r_rd_cnt != CNT_MAX) begin
                    new_cnt = r_rd_cnt + 1'b1;
                    do_wr   = 1'b1;
                end
            end else if (r_rd_cnt == '0) begin
                op_status = ST_ABSENT;
            end else begin
                new_cnt = r_rd_cnt - 1'b1;
                do_wr   = 1'b1;
            end
        end
    end

    // Memory write port shared by the clearing pass and updates.
    assign wr_addr = i_cmd.clr_step ? r_clr[POS_BITS-1:0] : r_pos;
    assign wr_occ  = i_cmd.clr_step ? 1'b0 : (new_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step || (i_cmd.wr && do_wr)) begin
            r_cnt_mem[wr_addr] <= i_cmd.clr_step ? '0 : new_cnt;
            r_occ_mem[wr_addr] <= wr_occ;
        end
        if (i_cmd.rd) r_rd_cnt <= r_cnt_mem[r_pos];
        r_occ_rd <= r_occ_mem[r_p[POS_BITS-1:0]];
    end

    // Clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)             r_clr <= '0;
        else if (i_cmd.clr_step)  r_clr <= r_clr + 1'b1;
    end
    assign o_stat.clr_last = (r_clr == (POS_BITS+1)'(DEPTH - 1));

    // Scan: one occupancy bit is read per cycle and checked in the next cycle.
    assign gap_here = r_chk_p - r_prev;
    assign gap_end  = len_ext - r_prev;
    assign best_fin = (gap_end > r_best) ? gap_end : r_best;
    assign o_stat.scan_last = !r_chk && (r_p >= len_ext);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos <= n_pos;
            r_cmd <= i_command;
        end
        if (i_cmd.wr) r_status <= op_status;
        if (i_cmd.scan_start) begin
            r_p    <= (POS_BITS+1)'(1);
            r_prev <= '0;
            r_best <= '0;
            r_chk  <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_chk   <= (r_p < len_ext);
            r_chk_p <= r_p;
            if (r_p < len_ext) r_p <= r_p + 1'b1;
            if (r_chk && r_occ_rd) begin
                if (gap_here > r_best) r_best <= gap_here;
                r_prev <= r_chk_p;
            end
        end
        if (i_cmd.out_load) begin
            r_gap   <= 10'(best_fin);
            r_ostat <= r_status;
        end
    end

    assign o_largest_gap = r_gap;
    assign o_status      = r_ostat;
endmodule

// File: sv/mgps_ctrl.sv
// Controller: sequences the clearing pass after reset, then update and scan for each request.
module mgps_ctrl import mgps_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    output logic  o_cfg_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    `include "max_gap_point_set_unit_defines.svh"

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   out_take;

    assign out_take = r_ovalid && i_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_valid) n_state = S_READ;
            S_READ:  n_state = S_WRITE;
            S_WRITE: n_state = S_SCAN;
            S_SCAN:  if (i_stat.scan_last) n_state = S_DONE;
            S_DONE:  if (!r_ovalid || out_take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = '0;
        o_ready    = 1'b0;
        n_ovalid   = r_ovalid && !i_ready;
        case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_READ:  o_cmd.rd = 1'b1;
            S_WRITE: begin
                o_cmd.wr         = 1'b1;
                o_cmd.scan_start = 1'b1;
            end
            S_SCAN:  o_cmd.scan_step = 1'b1;
            S_DONE: if (!r_ovalid || out_take) begin
                o_cmd.out_load = 1'b1;
                n_ovalid       = 1'b1;
            end
            default: ;
        endcase
    end

    // The length may only change while idle and no request is being taken.
    assign o_valid     = r_ovalid;
    assign o_cfg_ready = (r_state == S_IDLE) && !i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    `MGPS_ASSERT(a_no_accept_in_clear, i_clk, i_rst_n, (r_state == S_CLEAR) |-> !o_ready, "request accepted during clearing")
    `MGPS_ASSERT(a_result_after_done, i_clk, i_rst_n, o_cmd.out_load |=> o_valid, "result not presented")
    `MGPS_ASSERT(a_write_after_read, i_clk, i_rst_n, o_cmd.rd |=> o_cmd.wr, "update did not follow read")
    `MGPS_ASSERT(a_held_result, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid, "result dropped while stalled")
endmodule

// File: sv/max_gap_point_set_unit.sv
// Top level of the maximum-gap point set unit.
// After reset the unit clears its count store, one position per cycle, over
// all 2^POS_BITS positions (1024 by default) and accepts no request
// meanwhile. Each request then takes one read and one write of the count
// store, then a scan of the occupancy store one position per cycle from 1
// up to road_length - 1, then the result register load. The output
// register lets a finished result wait while the unit returns to idle; the
// next request is taken only once the previous result has been loaded.
// The length register is written through its own channel while idle.
module max_gap_point_set_unit import mgps_pkg::*; #(
    parameter int unsigned POS_BITS   = POS_BITS_DEF,
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_command,
    input  logic [9:0]          i_position,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [9:0]          o_largest_gap,
    output logic [1:0]          o_status,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [LEN_BITS-1:0] i_cfg_road_length
);
    t_cmd  cmd;
    t_stat stat;
    logic [LEN_BITS-1:0] r_len;

    // Road length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                       r_len <= LEN_BITS'(1023);
        else if (i_cfg_valid && o_cfg_ready) r_len <= i_cfg_road_length;
    end

    mgps_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .o_cfg_ready, .i_stat(stat), .o_cmd(cmd)
    );

    mgps_datapath #(.POS_BITS(POS_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat), .i_len(r_len),
        .i_command, .i_position, .o_largest_gap, .o_status
    );
endmodule

// File: tb/max_gap_point_set_unit_tb.sv
// Testbench for the maximum-gap point set unit: scoreboard, stimulus and checks.
module max_gap_point_set_unit_tb;
    import mgps_pkg::*;

    localparam int COUNT_MAX = 65535;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Gap scoreboard: holds its own copy of the counts and the length.
    class gap_scoreboard;
        int unsigned counts[1024];
        logic [9:0]  length;
        logic [9:0]  gap_q[$];
        logic [1:0]  status_q[$];
        int          errors;

        function void clear_all();
            foreach (counts[i]) counts[i] = 0;
            length = 10'd1023;
            errors = 0;
        endfunction

        function logic [9:0] widest_gap();
            int unsigned prev;
            int unsigned best;
            prev = 0;
            best = 0;
            for (int unsigned p = 1; p < length; p++) begin
                if (counts[p] != 0) begin
                    if (p - prev > best) best = p - prev;
                    prev = p;
                end
            end
            if (length - prev > best) best = length - prev;
            return best[9:0];
        endfunction

        // Note an accepted request and work out its expected result.
        function void note_request(logic [1:0] cmd, logic [9:0] pos);
            logic [1:0] st;
            st = ST_OK;
            if (cmd == CMD_ADD || cmd == CMD_REMOVE) begin
                if (pos == 0 || pos >= length) begin
                    st = ST_RANGE;
                end else if (cmd == CMD_ADD) begin
                    if (counts[pos] < COUNT_MAX) counts[pos]++;
                end else if (counts[pos] == 0) begin
                    st = ST_ABSENT;
                end else begin
                    counts[pos]--;
                end
            end
            gap_q.push_back(widest_gap());
            status_q.push_back(st);
        endfunction

        // Compare one result with the oldest expectation.
        function void check_result(logic [9:0] gap, logic [1:0] st);
            logic [9:0] eg;
            logic [1:0] es;
            if (gap_q.size() == 0) begin
                $display("%0t: unexpected result gap %0d status %0d", $time, gap, st);
                errors++;
                return;
            end
            eg = gap_q.pop_front();
            es = status_q.pop_front();
            if (gap !== eg) begin
                $display("%0t: gap expected %0d actual %0d", $time, eg, gap);
                errors++;
            end
            if (st !== es) begin
                $display("%0t: status expected %0d actual %0d", $time, es, st);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_command = '0;
    logic [9:0] i_position = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [9:0] o_largest_gap;
    logic [1:0] o_status;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [9:0] i_cfg_road_length = '0;

    gap_scoreboard board;
    bit            calm = 1'b0;
    int unsigned   cycles = 0;

    max_gap_point_set_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // Timeout guard: the test is failed if the run outlives the cycle limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 8000000) begin
            $display("max_gap_point_set_unit test failed");
            $finish;
        end
    end

    // Result side: check accepted results and stall at random in bursts.
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready && i_rst_n) board.check_result(o_largest_gap, o_status);
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 9) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Valid is left high after acceptance; this task drops it only for an idle burst.
    task automatic send_request(logic [1:0] cmd, logic [9:0] pos);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_position <= pos;
        do @(posedge i_clk); while (!o_ready);
        board.note_request(cmd, pos);
    endtask

    task automatic set_length(logic [9:0] len);
        i_valid <= 1'b0;
        while (board.gap_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_road_length <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.length = len;
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly in-range adds and removes on a small working set, some noise.
    task automatic random_phase(int n, logic [9:0] len);
        logic [1:0] cmd;
        logic [9:0] pos;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0: pos = 10'($urandom_range(0, 1023));
                1: pos = len;
                default: pos = (len > 1) ? 10'($urandom_range(1, len - 1)) : 10'd0;
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: cmd = CMD_ADD;
                4, 5, 6, 7: cmd = CMD_REMOVE;
                8: cmd = CMD_QUERY;
                default: cmd = CMD_UNUSED;
            endcase
            send_request(cmd, pos);
        end
    endtask

    initial begin
        board = new();
        board.clear_all();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every command, range and absent cases.
        send_request(CMD_QUERY, 10'd0);
        send_request(CMD_ADD, 10'd0);
        send_request(CMD_ADD, 10'd1023);
        send_request(CMD_ADD, 10'd1);
        send_request(CMD_ADD, 10'd1022);
        send_request(CMD_ADD, 10'd512);
        send_request(CMD_ADD, 10'd512);
        send_request(CMD_REMOVE, 10'd512);
        send_request(CMD_REMOVE, 10'd512);
        send_request(CMD_REMOVE, 10'd512);
        send_request(CMD_REMOVE, 10'd0);
        send_request(CMD_UNUSED, 10'h3FF);
        send_request(CMD_QUERY, 10'h2AA);
        send_request(CMD_ADD, 10'h155);
        send_request(CMD_ADD, 10'h2AA);

        // Short length: points beyond it are kept but ignored.
        set_length(10'd20);
        send_request(CMD_QUERY, 10'd0);
        send_request(CMD_ADD, 10'd19);
        send_request(CMD_ADD, 10'd20);
        send_request(CMD_REMOVE, 10'd512);
        random_phase(250, 10'd20);

        set_length(10'd2);
        send_request(CMD_ADD, 10'd1);
        random_phase(100, 10'd2);

        set_length(10'd64);
        random_phase(400, 10'd64);

        set_length(10'd300);
        random_phase(150, 10'd300);

        set_length(10'd1023);
        random_phase(200, 10'd1023);

        set_length(10'd40);
        random_phase(150, 10'd40);
        calm = 1'b1;
        random_phase(150, 10'd40);

        i_valid <= 1'b0;
        while (board.gap_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("max_gap_point_set_unit test passed");
        end else begin
            $display("max_gap_point_set_unit test failed");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+sv
sv/mgps_pkg.sv
sv/mgps_datapath.sv
sv/mgps_ctrl.sv
sv/max_gap_point_set_unit.sv
tb/max_gap_point_set_unit_tb.sv
